>>> sv/buddy_block_allocator_macros.svh
// Assertion macros shared by the allocator modules.
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define BBA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Antecedent in this cycle implies consequent in the next.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bba_pkg.sv
// Types, constants and codes shared by the buddy block allocator.
package bba_pkg;

    localparam int MEM_UNITS_DEF = 1024;
    localparam int MIN_BLOCK_DEF = 32;
    localparam int ID_BITS_DEF   = 16;

    localparam int PROC_ID_W  = 16;
    localparam int REQ_SIZE_W = 11;
    localparam int STATUS_W   = 2;
    localparam int OFFSET_W   = 10;
    localparam int SIZE_W     = 11;

    typedef enum logic {
        REQ_ALLOC   = 1'b0,
        REQ_RELEASE = 1'b1
    } t_req_type;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED   = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_RELEASED  = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_CLEAR   = 4'd1,
        OP_LOAD    = 4'd2,
        OP_DESCEND = 4'd3,
        OP_SPLIT   = 4'd4,
        OP_NEXT    = 4'd5,
        OP_UP      = 4'd6,
        OP_GRANT   = 4'd7,
        OP_FREE    = 4'd8,
        OP_MERGE   = 4'd9
    } t_op;

    typedef struct packed {
        logic is_rel;
        logic node_split;
        logic node_used;
        logic owner_match;
        logic too_small;
        logic take;
        logic at_root;
        logic is_right;
        logic parent_root;
        logic sib_free;
        logic clr_last;
    } t_dp_status;

    typedef struct packed {
        t_status               status;
        logic [OFFSET_W-1:0]   offset;
        logic [SIZE_W-1:0]     size;
    } t_result;

endpackage

>>> sv/bba_if.sv
// Request and response channel interfaces of the allocator.
interface bba_req_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic [bba_pkg::PROC_ID_W-1:0]    proc_id;
    logic [bba_pkg::REQ_SIZE_W-1:0]   req_size;

    modport source (output valid, req_type, proc_id, req_size, input ready);
    modport sink   (input valid, req_type, proc_id, req_size, output ready);
endinterface

interface bba_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [bba_pkg::STATUS_W-1:0]     status;
    logic [bba_pkg::OFFSET_W-1:0]     block_offset;
    logic [bba_pkg::SIZE_W-1:0]       block_size;

    modport source (output valid, status, block_offset, block_size, input ready);
    modport sink   (input valid, status, block_offset, block_size, output ready);
endinterface

>>> sv/bba_ctrl.sv
// Sequencer for tree search, release and merge of the buddy allocator.
`include "buddy_block_allocator_macros.svh"

module bba_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bba_pkg::t_dp_status i_status,
    output bba_pkg::t_op        o_op,
    output logic                o_res_valid,
    input  logic                i_out_free
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_VISIT  = 6'b000100,
        S_ASCEND = 6'b001000,
        S_MERGE  = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_op    = bba_pkg::OP_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_op = bba_pkg::OP_CLEAR;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = bba_pkg::OP_LOAD;
                    n_state = S_VISIT;
                end
            end
            S_VISIT: begin
                if (i_status.is_rel) begin
                    if (i_status.node_split) begin
                        o_op = bba_pkg::OP_DESCEND;
                    end else if (i_status.node_used && i_status.owner_match) begin
                        o_op    = bba_pkg::OP_FREE;
                        n_state = i_status.at_root ? S_DONE : S_MERGE;
                    end else begin
                        n_state = S_ASCEND;
                    end
                end else begin
                    if (i_status.too_small) begin
                        n_state = S_ASCEND;
                    end else if (i_status.node_split) begin
                        o_op = bba_pkg::OP_DESCEND;
                    end else if (i_status.node_used) begin
                        n_state = S_ASCEND;
                    end else if (i_status.take) begin
                        o_op    = bba_pkg::OP_GRANT;
                        n_state = S_DONE;
                    end else begin
                        o_op = bba_pkg::OP_SPLIT;
                    end
                end
            end
            S_ASCEND: begin
                // right child: climb; left child: try the sibling
                if (i_status.at_root) begin
                    n_state = S_DONE;
                end else if (i_status.is_right) begin
                    o_op = bba_pkg::OP_UP;
                end else begin
                    o_op    = bba_pkg::OP_NEXT;
                    n_state = S_VISIT;
                end
            end
            S_MERGE: begin
                if (i_status.sib_free) begin
                    o_op = bba_pkg::OP_MERGE;
                    if (i_status.parent_root) begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    `BBA_ASSERT_NEXT(a_accept_starts_search, i_in_valid && o_in_ready, r_state == S_VISIT, "accepted request did not start a search")
    `BBA_ASSERT_NEXT(a_result_held, o_res_valid && !i_out_free, o_res_valid, "pending result dropped before output register freed")
    `BBA_ASSERT_ALWAYS(a_merge_on_release, (r_state != S_MERGE) || i_status.is_rel, "merge pass entered on an allocate request")

endmodule

>>> sv/bba_datapath.sv
// Node store, tree walk registers and result formatting of the allocator.
`include "buddy_block_allocator_macros.svh"

module bba_datapath #(
    parameter int MEM_UNITS = bba_pkg::MEM_UNITS_DEF,
    parameter int MIN_BLOCK = bba_pkg::MIN_BLOCK_DEF,
    parameter int ID_BITS   = bba_pkg::ID_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bba_pkg::t_op                      i_op,
    input  logic                              i_req_type,
    input  logic [bba_pkg::PROC_ID_W-1:0]     i_proc_id,
    input  logic [bba_pkg::REQ_SIZE_W-1:0]    i_req_size,
    output bba_pkg::t_dp_status               o_status,
    output bba_pkg::t_result                  o_result
);

    localparam int LMEM   = $clog2(MEM_UNITS);
    localparam int LEVELS = LMEM - $clog2(MIN_BLOCK);
    localparam int NODES  = 2 ** (LEVELS + 1) - 1;
    localparam int IW     = LEVELS + 1;
    localparam int DW     = (LEVELS > 0) ? $clog2(LEVELS + 1) : 1;
    localparam int SW     = LMEM + 1;
    localparam int CW     = (SW > bba_pkg::REQ_SIZE_W) ? SW : bba_pkg::REQ_SIZE_W;
    localparam int OW     = LMEM;
    localparam int SHW    = $clog2(LMEM + 1);
    localparam int MW     = ID_BITS + 2;
    localparam int SPLIT_BIT = MW - 1;
    localparam int USED_BIT  = MW - 2;

    // node word: split, used, owner
    logic [MW-1:0]          r_mem [NODES];
    logic [MW-1:0]          r_rd_data;

    logic                   r_is_rel;
    logic [ID_BITS-1:0]     r_id;
    logic [bba_pkg::REQ_SIZE_W-1:0] r_req;
    logic [IW-1:0]          r_idx;
    logic [DW-1:0]          r_depth;
    logic [IW-1:0]          r_clr;
    logic                   r_found;
    logic [IW-1:0]          r_res_idx;
    logic [DW-1:0]          r_res_depth;

    logic [IW-1:0]          n_idx;
    logic [DW-1:0]          n_depth;
    logic [IW-1:0]          n_clr;
    logic                   n_found;

    logic [IW-1:0]          w_left;
    logic [IW-1:0]          w_next;
    logic [IW-1:0]          w_parent;
    logic [IW-1:0]          w_sib;
    logic [IW-1:0]          w_psib;
    logic [SW-1:0]          w_size;
    logic [CW-1:0]          w_size_c;
    logic [CW-1:0]          w_req_c;

    logic                   w_wr_en;
    logic [IW-1:0]          w_wr_addr;
    logic [MW-1:0]          w_wr_data;
    logic                   w_rd_en;
    logic [IW-1:0]          w_rd_addr;

    logic [SW-1:0]          w_res_size;
    logic [IW-1:0]          w_pos;
    logic [SHW-1:0]         w_shamt;
    logic [OW-1:0]          w_off;

    logic                   w_on_level;
    logic                   w_rw_clash;

    // tree navigation in heap order
    assign w_left   = IW'({r_idx, 1'b1});
    assign w_next   = r_idx + IW'(1);
    assign w_parent = IW'((r_idx - IW'(1)) >> 1);
    assign w_sib    = r_idx[0] ? (r_idx + IW'(1)) : (r_idx - IW'(1));
    assign w_psib   = w_parent[0] ? (w_parent + IW'(1)) : (w_parent - IW'(1));

    assign w_size   = SW'(MEM_UNITS) >> r_depth;
    assign w_size_c = CW'(w_size);
    assign w_req_c  = CW'(r_req);

    always_comb begin
        o_status.is_rel      = r_is_rel;
        o_status.node_split  = r_rd_data[SPLIT_BIT];
        o_status.node_used   = r_rd_data[USED_BIT];
        o_status.owner_match = (r_rd_data[ID_BITS-1:0] == r_id);
        o_status.too_small   = (w_size_c < w_req_c);
        o_status.take        = (w_req_c > (w_size_c >> 1)) || (r_depth == DW'(LEVELS));
        o_status.at_root     = (r_idx == '0);
        o_status.is_right    = !r_idx[0];
        o_status.parent_root = (w_parent == '0);
        o_status.sib_free    = !r_rd_data[SPLIT_BIT] && !r_rd_data[USED_BIT];
        o_status.clr_last    = (r_clr == IW'(NODES - 1));
    end

    // memory port control and walk register updates
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_idx;
        w_wr_data = {2'b00, r_id};
        w_rd_en   = 1'b0;
        w_rd_addr = r_idx;
        n_idx     = r_idx;
        n_depth   = r_depth;
        n_clr     = r_clr;
        n_found   = r_found;
        unique case (i_op)
            bba_pkg::OP_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr;
                w_wr_data = '0;
                n_clr     = r_clr + IW'(1);
            end
            bba_pkg::OP_LOAD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = '0;
                n_idx     = '0;
                n_depth   = '0;
                n_found   = 1'b0;
            end
            bba_pkg::OP_DESCEND: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_left;
                n_idx     = w_left;
                n_depth   = r_depth + DW'(1);
            end
            bba_pkg::OP_SPLIT: begin
                // children of an unsplit node are always free leaves already
                w_wr_en   = 1'b1;
                w_wr_data = {2'b10, r_id};
                w_rd_en   = 1'b1;
                w_rd_addr = w_left;
                n_idx     = w_left;
                n_depth   = r_depth + DW'(1);
            end
            bba_pkg::OP_NEXT: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_next;
                n_idx     = w_next;
            end
            bba_pkg::OP_UP: begin
                n_idx     = w_parent;
                n_depth   = r_depth - DW'(1);
            end
            bba_pkg::OP_GRANT: begin
                w_wr_en   = 1'b1;
                w_wr_data = {2'b01, r_id};
                n_found   = 1'b1;
            end
            bba_pkg::OP_FREE: begin
                // the root has no sibling to fetch
                w_wr_en   = 1'b1;
                w_wr_data = {2'b00, r_id};
                w_rd_en   = (r_idx != '0);
                w_rd_addr = w_sib;
                n_found   = 1'b1;
            end
            bba_pkg::OP_MERGE: begin
                // only ancestors of the freed leaf can become mergeable
                w_wr_en   = 1'b1;
                w_wr_addr = w_parent;
                w_wr_data = {2'b00, r_id};
                w_rd_en   = (w_parent != '0);
                w_rd_addr = w_psib;
                n_idx     = w_parent;
                n_depth   = r_depth - DW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_depth <= '0;
            r_clr   <= '0;
            r_found <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_depth <= n_depth;
            r_clr   <= n_clr;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == bba_pkg::OP_LOAD) begin
            r_is_rel <= (i_req_type == bba_pkg::REQ_RELEASE);
            r_id     <= ID_BITS'(i_proc_id);
            r_req    <= i_req_size;
        end
        if (i_op == bba_pkg::OP_GRANT || i_op == bba_pkg::OP_FREE) begin
            r_res_idx   <= r_idx;
            r_res_depth <= r_depth;
        end
    end

    // offset = (index - first index of level) * block size of level
    assign w_res_size = SW'(MEM_UNITS) >> r_res_depth;
    assign w_pos      = (r_res_idx + IW'(1)) ^ (IW'(1) << r_res_depth);
    assign w_shamt    = SHW'(LMEM) - SHW'(r_res_depth);
    assign w_off      = OW'(w_pos) << w_shamt;

    always_comb begin
        if (r_is_rel) begin
            o_result.status = r_found ? bba_pkg::ST_RELEASED : bba_pkg::ST_NOT_FOUND;
        end else begin
            o_result.status = r_found ? bba_pkg::ST_GRANTED : bba_pkg::ST_NO_FIT;
        end
        o_result.offset = r_found ? bba_pkg::OFFSET_W'(w_off) : '0;
        o_result.size   = r_found ? bba_pkg::SIZE_W'(w_res_size) : '0;
    end

    assign w_on_level = ((((IW+1)'(r_idx) + (IW+1)'(1)) >> r_depth) == (IW+1)'(1));
    assign w_rw_clash = w_wr_en && w_rd_en && (w_wr_addr == w_rd_addr);

    `BBA_ASSERT_ALWAYS(a_idx_matches_depth, w_on_level, "walk index off its level")
    `BBA_ASSERT_ALWAYS(a_no_rw_clash, !w_rw_clash, "node store read and written at one address")

endmodule

>>> sv/buddy_block_allocator.sv
// Buddy block allocator top level: sequencer, datapath and response register.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  i_req    | in  | valid / ready | req_type, proc_id, req_size
//  o_rsp    | out | valid / ready | status, block_offset, block_size
//
// After reset a clearing pass writes every tree node (63 at the default sizes),
// one per cycle; no request is taken until it ends.
// The depth-first walk enters each visited node and backs out of it through the
// sequencer states; the node store has one read and one write port. A request
// holds the block until its result is passed on, and a release then checks for
// a merge at each level it climbs while the buddy is free.
// The response register holds one result while the next request is searched;
// the sequencer only waits at its end if that register is still full.
module buddy_block_allocator #(
    parameter int MEM_UNITS = bba_pkg::MEM_UNITS_DEF,
    parameter int MIN_BLOCK = bba_pkg::MIN_BLOCK_DEF,
    parameter int ID_BITS   = bba_pkg::ID_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bba_req_if.sink     i_req,
    bba_rsp_if.source   o_rsp
);

    bba_pkg::t_op        w_op;
    bba_pkg::t_dp_status w_status;
    bba_pkg::t_result    w_result;
    logic                w_in_ready;
    logic                w_res_valid;
    logic                w_out_free;

    logic                r_out_valid;
    bba_pkg::t_result    r_out;

    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (w_in_ready),
        .i_status    (w_status),
        .o_op        (w_op),
        .o_res_valid (w_res_valid),
        .i_out_free  (w_out_free)
    );

    bba_datapath #(
        .MEM_UNITS (MEM_UNITS),
        .MIN_BLOCK (MIN_BLOCK),
        .ID_BITS   (ID_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_op),
        .i_req_type (i_req.req_type),
        .i_proc_id  (i_req.proc_id),
        .i_req_size (i_req.req_size),
        .o_status   (w_status),
        .o_result   (w_result)
    );

    assign i_req.ready = w_in_ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_out_free) begin
            r_out <= w_result;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.block_offset = r_out.offset;
    assign o_rsp.block_size   = r_out.size;

endmodule
